// File: src/amv_pkg.sv
// Package for the alarm message validator: character codes, length limits,
// configuration register indexes and byte class helpers.
// No dependencies.
package amv_pkg;

  // byte and register widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CNT_W    = 8;

  // section length limits
  localparam logic [CNT_W-1:0] ID_MAX_LEN   = 8'd16;
  localparam logic [CNT_W-1:0] DESIG_LEN    = 8'd3;
  localparam logic [CNT_W-1:0] TEXT_MAX_LEN = 8'd80;

  // character codes
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_FIVE  = 8'h35;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LC_F  = 8'h66;
  localparam logic [BYTE_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UC_F  = 8'h46;

  // delimiter reset values
  localparam logic [BYTE_W-1:0] RST_ID_OPEN    = 8'd91;
  localparam logic [BYTE_W-1:0] RST_ID_CLOSE   = 8'd93;
  localparam logic [BYTE_W-1:0] RST_DESIG_OPEN  = 8'd123;
  localparam logic [BYTE_W-1:0] RST_DESIG_CLOSE = 8'd125;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ID_OPEN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ID_CLOSE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DESIG_OPEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DESIG_CLOSE = 3'd3;

  // decimal digit test
  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // hex digit test, either case
  function automatic logic is_hex(input logic [BYTE_W-1:0] b);
    return is_digit(b) || ((b >= CH_LC_A) && (b <= CH_LC_F)) ||
           ((b >= CH_UC_A) && (b <= CH_UC_F));
  endfunction

endpackage

// File: src/alarm_message_validator.sv
// Alarm message validator top level: byte parser state, verdict register.
// Depends on amv_pkg.
//
// Usage:
//   Bytes of an alarm message enter on the s_axis channel, one per beat,
//   with s_axis_tlast set on the final byte. A level digit comes first,
//   then optional id, designator and text sections in any order.
//   One beat leaves on m_axis for every final byte: bit 0 of m_axis_tdata
//   is 1 when the message was well formed. Other bytes give no beat.
//   The four delimiter bytes are set through cfg_we/cfg_index/cfg_data
//   while no message is in flight; indexes above three are ignored.
// Timing:
//   A byte is checked in the cycle it is accepted; the verdict sits in the
//   output register from the next cycle on.
//   One byte per cycle is taken while no verdict waits on m_axis_tready, set by the single parser state update.
// Reset and stall:
//   rst clears the parser, empties the output register and restores the
//   default delimiters. While a verdict waits on m_axis_tready, input is
//   held off; once it is taken, a new byte enters in the same cycle.
module alarm_message_validator (
  input  logic                          clk,
  input  logic                          rst,
  // input bytes
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [amv_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tlast,   // end_of_msg
  // verdicts
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [amv_pkg::BYTE_W-1:0]    m_axis_tdata,   // [0] msg_valid, [7:1] zero
  // configuration writes
  input  logic                          cfg_we,
  input  logic [amv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [amv_pkg::BYTE_W-1:0]    cfg_data
);
  import amv_pkg::*;

  typedef enum logic [2:0] {
    PH_LEVEL,
    PH_TOP,
    PH_ID,
    PH_DESIG,
    PH_TEXT
  } phase_t;

  // delimiter registers
  logic [BYTE_W-1:0] id_open;
  logic [BYTE_W-1:0] id_close;
  logic [BYTE_W-1:0] desig_open;
  logic [BYTE_W-1:0] desig_close;

  // parser state
  phase_t            phase, phase_next;
  logic              seen_id, seen_id_next;
  logic              seen_desig, seen_desig_next;
  logic              seen_text, seen_text_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              failed, failed_next;

  // output register
  logic              out_valid;
  logic              out_ok;

  logic              in_beat;
  logic              is_delim;
  logic              top_byte;
  logic              verdict;
  logic [BYTE_W-1:0] b;

  assign b       = s_axis_tdata;
  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign is_delim = (b == id_open) || (b == id_close) ||
                    (b == desig_open) || (b == desig_close);

  // input side may move whenever the output slot is free or draining
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(BYTE_W-1){1'b0}}, out_ok};

  // delimiter register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      id_open     <= RST_ID_OPEN;
      id_close    <= RST_ID_CLOSE;
      desig_open  <= RST_DESIG_OPEN;
      desig_close <= RST_DESIG_CLOSE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ID_OPEN:     id_open     <= cfg_data;
        REG_ID_CLOSE:    id_close    <= cfg_data;
        REG_DESIG_OPEN:  desig_open  <= cfg_data;
        REG_DESIG_CLOSE: desig_close <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-byte parser step
  always_comb begin
    phase_next      = phase;
    seen_id_next    = seen_id;
    seen_desig_next = seen_desig;
    seen_text_next  = seen_text;
    count_next      = count;
    failed_next     = failed;
    top_byte        = 1'b0;

    if (!failed) begin
      case (phase)
        PH_LEVEL: begin
          if ((b < CH_ZERO) || (b > CH_FIVE)) failed_next = 1'b1;
          else phase_next = PH_TOP;
        end
        PH_ID: begin
          if (b == id_close) phase_next = PH_TOP;
          else if ((count >= ID_MAX_LEN) || is_delim || !is_hex(b)) failed_next = 1'b1;
          else count_next = count + 8'd1;
        end
        PH_DESIG: begin
          if (b == desig_close) begin
            if ((count != '0) && (count != DESIG_LEN)) failed_next = 1'b1;
            else phase_next = PH_TOP;
          end else if ((count >= DESIG_LEN) || is_delim || !is_digit(b)) begin
            failed_next = 1'b1;
          end else begin
            count_next = count + 8'd1;
          end
        end
        PH_TEXT: begin
          if (!is_delim) begin
            if (count >= TEXT_MAX_LEN) failed_next = 1'b1;
            else count_next = count + 8'd1;
          end else begin
            // delimiter ends the text and is parsed as a section start
            phase_next = PH_TOP;
            top_byte   = 1'b1;
          end
        end
        default: top_byte = 1'b1;
      endcase
    end

    // byte between sections: open a section or start the text
    if (top_byte) begin
      if (b == id_open) begin
        if (seen_id) failed_next = 1'b1;
        else begin
          seen_id_next = 1'b1;
          count_next   = '0;
          phase_next   = PH_ID;
        end
      end else if (b == desig_open) begin
        if (seen_desig) failed_next = 1'b1;
        else begin
          seen_desig_next = 1'b1;
          count_next      = '0;
          phase_next      = PH_DESIG;
        end
      end else if (seen_text || is_delim) begin
        failed_next = 1'b1;
      end else begin
        seen_text_next = 1'b1;
        count_next     = 8'd1;
        phase_next     = PH_TEXT;
      end
    end
  end

  assign verdict = !failed_next && (phase_next != PH_ID) && (phase_next != PH_DESIG);

  // parser state and verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEVEL;
      seen_id    <= 1'b0;
      seen_desig <= 1'b0;
      seen_text  <= 1'b0;
      count      <= '0;
      failed     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (m_axis_tready) out_valid <= 1'b0;
      if (in_beat) begin
        if (s_axis_tlast) begin
          phase      <= PH_LEVEL;
          seen_id    <= 1'b0;
          seen_desig <= 1'b0;
          seen_text  <= 1'b0;
          count      <= '0;
          failed     <= 1'b0;
          out_valid  <= 1'b1;
        end else begin
          phase      <= phase_next;
          seen_id    <= seen_id_next;
          seen_desig <= seen_desig_next;
          seen_text  <= seen_text_next;
          count      <= count_next;
          failed     <= failed_next;
        end
      end
    end
  end

  // verdict payload
  always_ff @(posedge clk) begin
    if (in_beat && s_axis_tlast) out_ok <= verdict;
  end

`ifndef SYNTHESIS
  // a final byte always produces a verdict beat
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    (in_beat && s_axis_tlast) |=> out_valid)
    else $error("final byte gave no verdict");

  // a final byte leaves the parser cleared for the next message
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (in_beat && s_axis_tlast) |=> (phase == PH_LEVEL) && !failed && (count == '0))
    else $error("parser not cleared after final byte");

  // section counters stay within their limits
  a_count_limits: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_ID) |-> (count <= ID_MAX_LEN)) and
    ((phase == PH_DESIG) |-> (count <= DESIG_LEN)) and
    ((phase == PH_TEXT) |-> (count <= TEXT_MAX_LEN)))
    else $error("section counter past its limit");

  // a byte that is not final never starts a new verdict
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !(in_beat && s_axis_tlast)) |=> !out_valid)
    else $error("verdict without final byte");
`endif

endmodule
